### sv/ska_pkg.sv
package ska_pkg;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int KEY_FIELD_W   = 32;
    localparam int VALUE_FIELD_W = 32;
    localparam int STATUS_W      = 2;
    localparam int POS_FIELD_W   = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_DONE
    } state_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic cmp_en;
        logic shift_en;
    } ska_ctrl_t;

endpackage

### sv/ska_if.sv
interface ska_req_if
    import ska_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [KEY_FIELD_W-1:0]   key;
    logic [VALUE_FIELD_W-1:0] payload;

    modport source (output valid, output command, output key, output payload, input ready);
    modport sink   (input valid, input command, input key, input payload, output ready);
endinterface

interface ska_rsp_if
    import ska_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [POS_FIELD_W-1:0]   position;
    logic [VALUE_FIELD_W-1:0] match_value;
    logic [POS_FIELD_W-1:0]   occupancy;

    modport source (output valid, output status, output position, output match_value,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input position, input match_value,
                    input occupancy, output ready);
endinterface

### sv/ska_cell.sv
module ska_cell
    import ska_pkg::*;
#(
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ska_ctrl_t              ctrl,
    input  logic [KEY_WIDTH-1:0]   new_key,
    input  logic [VALUE_WIDTH-1:0] new_value,
    input  logic                   prev_lt,
    input  logic                   prev_valid,
    input  logic [KEY_WIDTH-1:0]   prev_key,
    input  logic [VALUE_WIDTH-1:0] prev_value,
    output logic                   lt,
    output logic                   eq,
    output logic                   valid,
    output logic [KEY_WIDTH-1:0]   key,
    output logic [VALUE_WIDTH-1:0] value
);

    logic                   lt_reg;
    logic                   eq_reg;
    logic                   valid_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   take_new;
    logic                   take_prev;

    // the cell at the lower bound takes the new word, every cell above it
    // takes its lower neighbor's contents
    assign take_new  = ctrl.shift_en && !lt_reg && prev_lt;
    assign take_prev = ctrl.shift_en && !lt_reg && !prev_lt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.cmp_en)
            begin
                lt_reg <= valid_reg && (key_reg < new_key);
                eq_reg <= valid_reg && (key_reg == new_key);
            end
            if (take_new)
                valid_reg <= 1'b1;
            else if (take_prev)
                valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_new)
        begin
            key_reg   <= new_key;
            value_reg <= new_value;
        end
        else if (take_prev)
        begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

    assign lt    = lt_reg;
    assign eq    = eq_reg;
    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;

endmodule

### sv/ska_encode.sv
module ska_encode
    import ska_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    localparam int PW         = $clog2(CAPACITY + 1)
) (
    input  logic [CAPACITY-1:0]    lt,
    input  logic [CAPACITY-1:0]    eq,
    input  logic [VALUE_WIDTH-1:0] values [CAPACITY],
    output logic [PW-1:0]          position,
    output logic                   found,
    output logic [VALUE_WIDTH-1:0] value
);

    logic [CAPACITY-1:0] bound;
    logic [PW-1:0]       enc;

    // lt is a thermometer code over the sorted cells; bound marks its edge
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
                bound[i] = !lt[i];
            else
                bound[i] = lt[i-1] && !lt[i];
        end
    end

    always_comb
    begin
        enc   = '0;
        value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (bound[i])
                enc = enc | PW'(i);
            if (bound[i] && eq[i])
                value = value | values[i];
        end
    end

    assign position = lt[CAPACITY-1] ? PW'(CAPACITY) : enc;
    assign found    = |(bound & eq);

endmodule

### sv/sorted_key_value_table.sv
// Sorted key/value table held in a chain of cells, ascending by key.
// req channel (ska_req_if.sink): command, key, payload. command 0 inserts
// the word at the lower bound of key and shifts later entries up; command 1
// looks the key up. rsp channel (ska_rsp_if.source): status, position,
// match_value and occupancy, one word per request, in request order.
// Steps: an accepted request is registered, the CMP state runs the broadcast
// compare in every cell, and the DONE state does the boundary encode,
// registers the response and shifts the chain on an insert. A new request is
// accepted in the same cycle as that commit; a stalled receiver holds DONE.
// A full table drops an insert and reports status 2 with the lower bound.
// Reset empties the table (entry count and cell valid bits clear at once);
// the block takes requests in the first cycle after reset.
// When the receiver stalls, the finished response waits in the output
// register; one more request is accepted and compared, then req.ready stays
// low until the pending response is taken.
module sorted_key_value_table
    import ska_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    ska_req_if.sink   req,
    ska_rsp_if.source rsp
);

    localparam int PW = $clog2(CAPACITY + 1);

    state_t                   state_reg;
    state_t                   state_next;
    ska_ctrl_t                ctrl;
    logic                     accept;
    logic                     commit;
    logic                     full;

    logic                     cmd_reg;
    logic [KEY_WIDTH-1:0]     key_reg;
    logic [VALUE_WIDTH-1:0]   value_reg;
    logic [PW-1:0]            count_reg;

    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [POS_FIELD_W-1:0]   position_reg;
    logic [VALUE_FIELD_W-1:0] match_value_reg;
    logic [POS_FIELD_W-1:0]   occupancy_reg;

    logic [CAPACITY-1:0]      cell_lt;
    logic [CAPACITY-1:0]      cell_eq;
    logic [CAPACITY-1:0]      cell_valid;
    logic [KEY_WIDTH-1:0]     cell_key   [CAPACITY];
    logic [VALUE_WIDTH-1:0]   cell_value [CAPACITY];

    logic [PW-1:0]            lb_pos;
    logic                     lb_found;
    logic [VALUE_WIDTH-1:0]   lb_value;

    assign full   = (count_reg == PW'(CAPACITY));
    assign commit = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);
    assign accept = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CMP;
            ST_CMP:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (commit)
                    state_next = accept ? ST_CMP : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready     = 1'b0;
        ctrl.cmp_en   = 1'b0;
        ctrl.shift_en = 1'b0;
        unique case (state_reg)
            ST_IDLE: req.ready = 1'b1;
            ST_CMP:  ctrl.cmp_en = 1'b1;
            ST_DONE:
            begin
                req.ready     = commit;
                ctrl.shift_en = commit && (cmd_reg == CMD_INSERT) && !full;
            end
            default: req.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.shift_en)
                count_reg <= count_reg + PW'(1);
            if (commit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req.command;
            key_reg   <= KEY_WIDTH'({32'd0, req.key});
            value_reg <= VALUE_WIDTH'({32'd0, req.payload});
        end
        if (commit)
        begin
            position_reg <= POS_FIELD_W'(lb_pos);
            if (cmd_reg == CMD_INSERT)
            begin
                status_reg      <= full ? STATUS_FULL : STATUS_OK;
                match_value_reg <= '0;
                occupancy_reg   <= POS_FIELD_W'(full ? count_reg : count_reg + PW'(1));
            end
            else
            begin
                status_reg      <= lb_found ? STATUS_OK : STATUS_NOT_FOUND;
                match_value_reg <= lb_found ? VALUE_FIELD_W'({32'd0, lb_value}) : '0;
                occupancy_reg   <= POS_FIELD_W'(count_reg);
            end
        end
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                ska_cell #(
                    .KEY_WIDTH   (KEY_WIDTH),
                    .VALUE_WIDTH (VALUE_WIDTH)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .new_key    (key_reg),
                    .new_value  (value_reg),
                    .prev_lt    (1'b1),
                    .prev_valid (1'b0),
                    .prev_key   ('0),
                    .prev_value ('0),
                    .lt         (cell_lt[i]),
                    .eq         (cell_eq[i]),
                    .valid      (cell_valid[i]),
                    .key        (cell_key[i]),
                    .value      (cell_value[i])
                );
            end
            else
            begin : g_body
                ska_cell #(
                    .KEY_WIDTH   (KEY_WIDTH),
                    .VALUE_WIDTH (VALUE_WIDTH)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .new_key    (key_reg),
                    .new_value  (value_reg),
                    .prev_lt    (cell_lt[i-1]),
                    .prev_valid (cell_valid[i-1]),
                    .prev_key   (cell_key[i-1]),
                    .prev_value (cell_value[i-1]),
                    .lt         (cell_lt[i]),
                    .eq         (cell_eq[i]),
                    .valid      (cell_valid[i]),
                    .key        (cell_key[i]),
                    .value      (cell_value[i])
                );
            end
        end
    endgenerate

    ska_encode #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_encode (
        .lt       (cell_lt),
        .eq       (cell_eq),
        .values   (cell_value),
        .position (lb_pos),
        .found    (lb_found),
        .value    (lb_value)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.position    = position_reg;
    assign rsp.match_value = match_value_reg;
    assign rsp.occupancy   = occupancy_reg;

endmodule
